[rtl/core/quadrature_knob_decoder_top_assert.svh]
// Assertion macros for the knob decoder top level.
`ifndef QUADRATURE_KNOB_DECODER_TOP_ASSERT_SVH
`define QUADRATURE_KNOB_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define QKD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("knob decoder check failed");

// Next-cycle implication, held off during reset.
`define QKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knob decoder check failed");

`endif

[rtl/core/qkd_pkg.sv]
// Types, codes and tables shared by the knob decoder modules.
package qkd_pkg;

  localparam int NOTCH_COUNT_BITS = 16;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_RESYNC = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PRESS = 2'd1;
  localparam logic [1:0] EV_CW    = 2'd2;
  localparam logic [1:0] EV_CCW   = 2'd3;

  localparam logic [0:0] REG_STEPS_PER_NOTCH  = 1'd0;
  localparam logic [0:0] REG_DEBOUNCE_SAMPLES = 1'd1;

  localparam logic [3:0] STEPS_PER_NOTCH_RESET  = 4'd4;
  localparam logic [3:0] DEBOUNCE_SAMPLES_RESET = 4'd5;

  // Step for index {previous B, previous A, B, A}.
  localparam logic signed [1:0] QUAD_STEPS [16] = '{
     2'sd0,  2'sd1, -2'sd1,  2'sd0,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
     2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic       pin_a;
    logic       pin_b;
    logic       pin_button;
  } qkd_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       button_level;
  } qkd_result_t;

  // Decoded command of the item being processed this cycle.
  typedef struct packed {
    logic sample;
    logic read;
    logic resync;
  } qkd_op_t;

endpackage

[rtl/core/quadrature_knob_decoder_top.sv]
// Top level of the quadrature knob decoder with button debounce.
// Every beat is taken into an input register and processed from there, so one
// command per clock is sustained while the input side does not stall; a read
// delivers its result from the result register. Sample and resync beats give
// no result. The input side stalls only while a read waits in the input
// register and the result register holds a beat that is itself stalled.
// Configuration writes take effect on the next processed command.
module quadrature_knob_decoder_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  qkd_pkg::qkd_item_t    item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output qkd_pkg::qkd_result_t  result,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [3:0]            cfg_wdata
);
  import qkd_pkg::*;

  `include "quadrature_knob_decoder_top_assert.svh"

  logic       item_q_valid;
  qkd_item_t  item_q;
  logic [3:0] steps_per_notch;
  logic [3:0] debounce_samples;

  logic       result_free;
  logic       process;
  qkd_op_t    op;
  logic       press_pending;
  logic       stable_button;
  logic       count_pos;
  logic       count_neg;
  logic [1:0] event_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_notch  <= STEPS_PER_NOTCH_RESET;
      debounce_samples <= DEBOUNCE_SAMPLES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEPS_PER_NOTCH:  steps_per_notch  <= cfg_wdata;
        REG_DEBOUNCE_SAMPLES: debounce_samples <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign result_free = !result_valid || !result_stall;
  assign process     = item_q_valid && (item_q.cmd != CMD_READ || result_free);
  assign item_stall  = item_q_valid && !process;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      item_q <= item;
    end
  end

  always_comb begin
    op = '0;
    if (process) begin
      case (item_q.cmd)
        CMD_SAMPLE: op.sample = 1'b1;
        CMD_READ:   op.read   = 1'b1;
        CMD_RESYNC: op.resync = 1'b1;
        default:    op        = '0;
      endcase
    end
  end

  qkd_quad u_quad (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .ab              ({item_q.pin_b, item_q.pin_a}),
    .steps_per_notch (steps_per_notch),
    .consume         (op.read && !press_pending),
    .count_pos       (count_pos),
    .count_neg       (count_neg)
  );

  qkd_button u_button (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .pressed          (!item_q.pin_button),
    .debounce_samples (debounce_samples),
    .press_pending    (press_pending),
    .stable_button    (stable_button)
  );

  always_comb begin
    if (press_pending) begin
      event_code = EV_PRESS;
    end else if (count_pos) begin
      event_code = EV_CW;
    end else if (count_neg) begin
      event_code = EV_CCW;
    end else begin
      event_code = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op.read) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.read) begin
      result.event_code   <= event_code;
      result.button_level <= stable_button;
    end
  end

  `QKD_ASSERT_NEXT(a_read_gives_result, clk, rst, op.read, result_valid)
  `QKD_ASSERT_NEXT(a_no_spurious_result, clk, rst, result_free && !op.read, !result_valid)
  `QKD_ASSERT_NOW(a_stall_needs_read, clk, rst, item_stall, item_q_valid && item_q.cmd == CMD_READ)
  `QKD_ASSERT_NOW(a_read_needs_room, clk, rst, op.read, result_free)

endmodule

[rtl/core/qkd_quad.sv]
// Quadrature step decode, notch accumulator and saturating notch count.
module qkd_quad (
  input  logic              clk,
  input  logic              rst,
  input  qkd_pkg::qkd_op_t  op,
  input  logic [1:0]        ab,
  input  logic [3:0]        steps_per_notch,
  input  logic              consume,
  output logic              count_pos,
  output logic              count_neg
);
  import qkd_pkg::*;

  localparam logic signed [NOTCH_COUNT_BITS-1:0] NOTCH_MAX =
    {1'b0, {(NOTCH_COUNT_BITS-1){1'b1}}};
  localparam logic signed [NOTCH_COUNT_BITS-1:0] NOTCH_MIN =
    {1'b1, {(NOTCH_COUNT_BITS-1){1'b0}}};

  logic [1:0]                          previous_ab;
  logic signed [3:0]                   step_accumulator;
  logic signed [NOTCH_COUNT_BITS-1:0]  notch_count;

  logic signed [3:0]                   step_accumulator_next;
  logic signed [NOTCH_COUNT_BITS-1:0]  notch_count_next;
  logic signed [1:0]                   step;
  logic [3:0]                          notch_size;
  logic signed [4:0]                   sum;
  logic signed [4:0]                   size_ext;

  assign count_pos = !notch_count[NOTCH_COUNT_BITS-1] && (|notch_count);
  assign count_neg = notch_count[NOTCH_COUNT_BITS-1];

  always_comb begin
    if (steps_per_notch == 4'd0) begin
      notch_size = 4'd1;
    end else if (steps_per_notch > 4'd8) begin
      notch_size = 4'd8;
    end else begin
      notch_size = steps_per_notch;
    end
  end

  assign step     = QUAD_STEPS[{previous_ab, ab}];
  assign size_ext = $signed({1'b0, notch_size});
  assign sum      = $signed({step_accumulator[3], step_accumulator}) +
                    $signed({{3{step[1]}}, step});

  always_comb begin
    step_accumulator_next = step_accumulator;
    notch_count_next      = notch_count;
    if (op.sample && step != 2'sd0) begin
      if (sum >= size_ext) begin
        step_accumulator_next = 4'(sum - size_ext);
        if (notch_count != NOTCH_MAX) begin
          notch_count_next = notch_count + 1'b1;
        end
      end else if (sum <= -size_ext) begin
        step_accumulator_next = 4'(sum + size_ext);
        if (notch_count != NOTCH_MIN) begin
          notch_count_next = notch_count - 1'b1;
        end
      end else begin
        step_accumulator_next = sum[3:0];
      end
    end else if (consume) begin
      if (count_pos) begin
        notch_count_next = notch_count - 1'b1;
      end else if (count_neg) begin
        notch_count_next = notch_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab      <= 2'd3;
      step_accumulator <= '0;
      notch_count      <= '0;
    end else if (op.resync) begin
      previous_ab      <= ab;
      step_accumulator <= '0;
      notch_count      <= '0;
    end else begin
      if (op.sample) begin
        previous_ab <= ab;
      end
      step_accumulator <= step_accumulator_next;
      notch_count      <= notch_count_next;
    end
  end

endmodule

[rtl/core/qkd_button.sv]
// Button debounce by counting equal samples, with a pending press flag.
module qkd_button (
  input  logic              clk,
  input  logic              rst,
  input  qkd_pkg::qkd_op_t  op,
  input  logic              pressed,
  input  logic [3:0]        debounce_samples,
  output logic              press_pending,
  output logic              stable_button
);
  import qkd_pkg::*;

  logic       last_button_sample;
  logic [3:0] same_sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_button_sample <= 1'b0;
      stable_button      <= 1'b0;
      same_sample_count  <= '0;
      press_pending      <= 1'b0;
    end else if (op.resync) begin
      last_button_sample <= pressed;
      stable_button      <= pressed;
      same_sample_count  <= '0;
      press_pending      <= 1'b0;
    end else if (op.read) begin
      // A read reports a pending press first, so it always leaves none behind.
      press_pending <= 1'b0;
    end else if (op.sample) begin
      if (pressed == last_button_sample) begin
        if (same_sample_count < debounce_samples) begin
          same_sample_count <= same_sample_count + 4'd1;
        end else if (stable_button != pressed) begin
          stable_button <= pressed;
          if (pressed) begin
            press_pending <= 1'b1;
          end
        end
      end else begin
        same_sample_count  <= '0;
        last_button_sample <= pressed;
      end
    end
  end

endmodule
